### rtl/ncts_pkg.sv
`default_nettype none

package ncts_pkg;

  localparam int TABLE_DEPTH   = 256;
  localparam int KIND_COUNT    = 6;
  localparam int KINDS_DEFINED = 6;

  localparam int KIND_W  = 3;
  localparam int CMD_W   = 1;
  localparam int CNT_W   = 9;
  localparam int FREQ_W  = 16;
  localparam int WIPER_W = 8;
  localparam int ENTRY_W = 8;
  localparam int WORD_W  = FREQ_W + 2 * WIPER_W;
  localparam int CFG_IDX_W = 3;
  localparam int CW_CNT_W  = 3;
  localparam int OW_CNT_W  = 2;

  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int STORE_WORDS = KIND_COUNT * TABLE_DEPTH;
  localparam int ADDR_W      = $clog2(STORE_WORDS);

  localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

  localparam logic [KIND_W-1:0] KIND_LPF1 = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LPF5 = 3'd1;
  localparam logic [KIND_W-1:0] KIND_HPF1 = 3'd2;
  localparam logic [KIND_W-1:0] KIND_HPF5 = 3'd3;
  localparam logic [KIND_W-1:0] KIND_BPF2 = 3'd4;
  localparam logic [KIND_W-1:0] KIND_BPF6 = 3'd5;

  typedef logic [KINDS_DEFINED-1:0][CNT_W-1:0] count_arr_t;

  // index 5 (bpf6) leftmost down to index 0 (lpf1)
  localparam count_arr_t COUNT_RESET = {9'd255, 9'd255, 9'd47, 9'd71, 9'd255, 9'd255};

  function automatic logic kind_ok(input logic [KIND_W-1:0] kind);
    kind_ok = ({1'b0, kind} < (KIND_W + 1)'(KINDS_DEFINED)) &&
              ({1'b0, kind} < (KIND_W + 1)'(KIND_COUNT));
  endfunction

  function automatic logic [CW_CNT_W-1:0] cutoff_wipers(input logic [KIND_W-1:0] kind);
    case (kind)
      KIND_LPF1: cutoff_wipers = 3'd1;
      KIND_LPF5: cutoff_wipers = 3'd5;
      KIND_HPF1: cutoff_wipers = 3'd1;
      KIND_HPF5: cutoff_wipers = 3'd5;
      KIND_BPF2: cutoff_wipers = 3'd2;
      KIND_BPF6: cutoff_wipers = 3'd6;
      default:   cutoff_wipers = 3'd0;
    endcase
  endfunction

  function automatic logic [OW_CNT_W-1:0] offset_wipers(input logic [KIND_W-1:0] kind);
    case (kind)
      KIND_LPF1: offset_wipers = 2'd0;
      KIND_LPF5: offset_wipers = 2'd0;
      KIND_HPF1: offset_wipers = 2'd1;
      KIND_HPF5: offset_wipers = 2'd1;
      KIND_BPF2: offset_wipers = 2'd1;
      KIND_BPF6: offset_wipers = 2'd3;
      default:   offset_wipers = 2'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

### rtl/ncts_ram.sv
`default_nettype none

module ncts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

### rtl/ncts_cfg.sv
`default_nettype none

module ncts_cfg
  import ncts_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CNT_W-1:0]     cfg_data,
  output count_arr_t                counts
);

  count_arr_t counts_r;

  assign cfg_ready = 1'b1;
  assign counts    = counts_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counts_r <= COUNT_RESET;
    end else if (cfg_valid && cfg_ready &&
                 ({1'b0, cfg_index} < (CFG_IDX_W + 1)'(KINDS_DEFINED))) begin
      counts_r[cfg_index] <= cfg_data;
    end
  end

endmodule

`default_nettype wire

### rtl/ncts_scan.sv
`default_nettype none

module ncts_scan
  import ncts_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [CMD_W-1:0]    in_cmd,
  input  wire logic [KIND_W-1:0]   in_filter_kind,
  input  wire logic [ENTRY_W-1:0]  in_entry_index,
  input  wire logic [FREQ_W-1:0]   in_entry_freq,
  input  wire logic [WIPER_W-1:0]  in_entry_cutoff_wiper,
  input  wire logic [WIPER_W-1:0]  in_entry_offset_wiper,
  input  wire logic [FREQ_W-1:0]   in_cutoff_freq,
  input  wire count_arr_t          counts,
  output logic                     out_valid,
  output logic [ENTRY_W-1:0]       out_match_index,
  output logic [WIPER_W-1:0]       out_cutoff_wiper_value,
  output logic [WIPER_W-1:0]       out_offset_wiper_value,
  output logic [CW_CNT_W-1:0]      out_cutoff_wiper_count,
  output logic [OW_CNT_W-1:0]      out_offset_wiper_count
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    cur_r, cur_nxt;
  logic [IDX_W-1:0]    last_r, last_nxt;
  logic [ADDR_W-1:0]   base_r, base_nxt;
  logic [FREQ_W-1:0]   want_r, want_nxt;
  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [WORD_W-1:0]   prev_r, prev_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]    pick_r, pick_nxt;
  logic [WORD_W-1:0]   word_r, word_nxt;
  logic [KIND_W-1:0]   okind_r, okind_nxt;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_addr;
  logic [WORD_W-1:0]   ram_wdata;
  logic [WORD_W-1:0]   ram_rdata;

  logic                accept;
  logic [ADDR_W-1:0]   base_in;
  logic [CNT_W-1:0]    cnt_sel;
  logic [CNT_W-1:0]    used;
  logic [FREQ_W-1:0]   cur_freq;
  logic [FREQ_W-1:0]   prev_freq;
  logic [FREQ_W-1:0]   below;
  logic [FREQ_W-1:0]   above;

  ncts_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_WORDS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign base_in   = ADDR_W'(in_filter_kind) * ADDR_W'(TABLE_DEPTH);
  assign ram_wdata = {in_entry_offset_wiper, in_entry_cutoff_wiper, in_entry_freq};
  assign cur_freq  = ram_rdata[FREQ_W-1:0];
  assign prev_freq = prev_r[FREQ_W-1:0];
  assign below     = want_r - prev_freq;
  assign above     = cur_freq - want_r;

  always_comb begin
    cnt_sel = '0;
    if (kind_ok(in_filter_kind)) begin
      cnt_sel = counts[in_filter_kind];
    end
    if (cnt_sel == '0) begin
      used = CNT_W'(1);
    end else if (cnt_sel > CNT_W'(TABLE_DEPTH)) begin
      used = CNT_W'(TABLE_DEPTH);
    end else begin
      used = cnt_sel;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    last_nxt      = last_r;
    base_nxt      = base_r;
    want_nxt      = want_r;
    kind_nxt      = kind_r;
    prev_nxt      = prev_r;
    out_valid_nxt = 1'b0;
    pick_nxt      = pick_r;
    word_nxt      = word_r;
    okind_nxt     = okind_r;
    ram_we        = 1'b0;
    ram_addr      = base_r + ADDR_W'(cur_r);

    case (state_r)
      S_IDLE: begin
        ram_addr = base_in;
        if (accept && kind_ok(in_filter_kind)) begin
          if (in_cmd == CMD_LOAD) begin
            ram_addr = base_in + ADDR_W'(in_entry_index);
            ram_we   = ({1'b0, in_entry_index} < (ENTRY_W + 1)'(TABLE_DEPTH));
          end else begin
            // entry 0 read goes out now, data lands in the first scan cycle
            base_nxt  = base_in;
            want_nxt  = in_cutoff_freq;
            kind_nxt  = in_filter_kind;
            last_nxt  = IDX_W'(used - CNT_W'(1));
            cur_nxt   = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        prev_nxt = ram_rdata;
        if (cur_r != last_r) begin
          cur_nxt  = cur_r + IDX_W'(1);
          ram_addr = base_r + ADDR_W'(cur_r) + ADDR_W'(1);
        end
        if (cur_r == '0) begin
          if (cur_freq > want_r || last_r == '0) begin
            pick_nxt      = '0;
            word_nxt      = ram_rdata;
            okind_nxt     = kind_r;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else if (prev_freq <= want_r && cur_freq >= want_r) begin
          // tie goes to the upper entry
          if (below < above) begin
            pick_nxt = cur_r - IDX_W'(1);
            word_nxt = prev_r;
          end else begin
            pick_nxt = cur_r;
            word_nxt = ram_rdata;
          end
          okind_nxt     = kind_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (cur_r == last_r) begin
          pick_nxt      = cur_r;
          word_nxt      = ram_rdata;
          okind_nxt     = kind_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    last_r  <= last_nxt;
    base_r  <= base_nxt;
    want_r  <= want_nxt;
    kind_r  <= kind_nxt;
    prev_r  <= prev_nxt;
    pick_r  <= pick_nxt;
    word_r  <= word_nxt;
    okind_r <= okind_nxt;
  end

  assign out_valid              = out_valid_r;
  assign out_match_index        = ENTRY_W'(pick_r);
  assign out_cutoff_wiper_value = word_r[FREQ_W +: WIPER_W];
  assign out_offset_wiper_value = word_r[FREQ_W + WIPER_W +: WIPER_W];
  assign out_cutoff_wiper_count = cutoff_wipers(okind_r);
  assign out_offset_wiper_count = offset_wipers(okind_r);

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == S_IDLE)
    else $error("table write during scan");

  a_out_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r) == S_SCAN)
    else $error("result strobe without a scan");

  a_cur_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> cur_r <= last_r)
    else $error("scan index past last entry");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held two cycles");

endmodule

`default_nettype wire

### rtl/nearest_cutoff_table_search.sv
// Load: writes one table word at the accept edge, no result.
// Query: scans N table entries between accept and the out_valid strobe, N = entries
// scanned (1..256); the table RAM is read one entry per cycle.
// A new transaction may start in the cycle of the strobe; the receiver cannot stall.
// Synchronous active-low reset clears control and loads the count registers;
// table contents stay undefined until loaded.
`default_nettype none

module nearest_cutoff_table_search
  import ncts_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [CMD_W-1:0]     in_cmd,
  input  wire logic [KIND_W-1:0]    in_filter_kind,
  input  wire logic [ENTRY_W-1:0]   in_entry_index,
  input  wire logic [FREQ_W-1:0]    in_entry_freq,
  input  wire logic [WIPER_W-1:0]   in_entry_cutoff_wiper,
  input  wire logic [WIPER_W-1:0]   in_entry_offset_wiper,
  input  wire logic [FREQ_W-1:0]    in_cutoff_freq,
  output logic                      out_valid,
  output logic [ENTRY_W-1:0]        out_match_index,
  output logic [WIPER_W-1:0]        out_cutoff_wiper_value,
  output logic [WIPER_W-1:0]        out_offset_wiper_value,
  output logic [CW_CNT_W-1:0]       out_cutoff_wiper_count,
  output logic [OW_CNT_W-1:0]       out_offset_wiper_count,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CNT_W-1:0]     cfg_data
);

  count_arr_t counts;

  ncts_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .counts    (counts)
  );

  ncts_scan u_scan (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_cmd                 (in_cmd),
    .in_filter_kind         (in_filter_kind),
    .in_entry_index         (in_entry_index),
    .in_entry_freq          (in_entry_freq),
    .in_entry_cutoff_wiper  (in_entry_cutoff_wiper),
    .in_entry_offset_wiper  (in_entry_offset_wiper),
    .in_cutoff_freq         (in_cutoff_freq),
    .counts                 (counts),
    .out_valid              (out_valid),
    .out_match_index        (out_match_index),
    .out_cutoff_wiper_value (out_cutoff_wiper_value),
    .out_offset_wiper_value (out_offset_wiper_value),
    .out_cutoff_wiper_count (out_cutoff_wiper_count),
    .out_offset_wiper_count (out_offset_wiper_count)
  );

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench
  import ncts_pkg::*;
();

  localparam int ITEM_TARGET   = 1050;
  localparam int SETTLE_CYCLES = 300;
  localparam int STALL_LIMIT   = 3000;
  localparam int MAX_REPORTS   = 30;

  localparam logic [KIND_W-1:0] KIND_UNUSED6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_UNUSED7 = 3'd7;

  localparam logic [CFG_IDX_W-1:0] REG_LPF1   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LPF5   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HPF1   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HPF5   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BPF2   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BPF6   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE7 = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [KIND_W-1:0]  kind;
    logic [ENTRY_W-1:0] entry;
    logic [FREQ_W-1:0]  freq;
    logic [WIPER_W-1:0] cutoff_wiper;
    logic [WIPER_W-1:0] offset_wiper;
    logic [FREQ_W-1:0]  cutoff;
  } filter_req_t;

  typedef struct packed {
    logic [ENTRY_W-1:0]  match_index;
    logic [WIPER_W-1:0]  cutoff_wiper_value;
    logic [WIPER_W-1:0]  offset_wiper_value;
    logic [CW_CNT_W-1:0] cutoff_wiper_count;
    logic [OW_CNT_W-1:0] offset_wiper_count;
  } filter_pick_t;

  class cutoff_predictor;
    logic [FREQ_W-1:0]  freq_tbl   [STORE_WORDS];
    logic [WIPER_W-1:0] cutoff_tbl [STORE_WORDS];
    logic [WIPER_W-1:0] offset_tbl [STORE_WORDS];
    bit                 loaded     [STORE_WORDS];
    logic [CNT_W-1:0]   counts     [KINDS_DEFINED];
    filter_pick_t       expected_picks [$];
    int                 errors;

    function new();
      foreach (freq_tbl[i]) begin
        freq_tbl[i]   = '0;
        cutoff_tbl[i] = '0;
        offset_tbl[i] = '0;
        loaded[i]     = 1'b0;
      end
      counts[KIND_LPF1] = 9'hFF;
      counts[KIND_LPF5] = 9'hFF;
      counts[KIND_HPF1] = 9'd71;
      counts[KIND_HPF5] = 9'd47;
      counts[KIND_BPF2] = 9'hFF;
      counts[KIND_BPF6] = 9'hFF;
      errors = 0;
    endfunction

    function bit kind_valid(logic [KIND_W-1:0] kind);
      return int'(kind) < KIND_COUNT && int'(kind) < KINDS_DEFINED;
    endfunction

    function int used_entries(logic [KIND_W-1:0] kind);
      return (int'(counts[kind]) > TABLE_DEPTH) ? TABLE_DEPTH : int'(counts[kind]);
    endfunction

    // a count of zero still reads entry 0
    function int scan_len(logic [KIND_W-1:0] kind);
      return (used_entries(kind) == 0) ? 1 : used_entries(kind);
    endfunction

    function bit loaded_upto(logic [KIND_W-1:0] kind, int n);
      int base, i;
      base = int'(kind) * TABLE_DEPTH;
      for (i = 0; i < n; i++)
        if (!loaded[base + i]) return 1'b0;
      return 1'b1;
    endfunction

    function void set_count(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] data);
      if (int'(idx) < KINDS_DEFINED) counts[idx] = data;
    endfunction

    // first bracketing pair wins, closer side, tie to the upper entry
    function int nearest_entry(logic [KIND_W-1:0] kind, int want);
      int base, used, lo, hi, i;
      base = int'(kind) * TABLE_DEPTH;
      used = used_entries(kind);
      if (int'(freq_tbl[base]) > want) return 0;
      for (i = 1; i < used; i++) begin
        lo = freq_tbl[base + i - 1];
        hi = freq_tbl[base + i];
        if (lo <= want && hi >= want) return (want - lo < hi - want) ? i - 1 : i;
      end
      return (used == 0) ? 0 : used - 1;
    endfunction

    function logic [CW_CNT_W-1:0] cutoff_wiper_total(logic [KIND_W-1:0] kind);
      case (kind)
        KIND_LPF5, KIND_HPF5: return 3'd5;
        KIND_BPF2:            return 3'd2;
        KIND_BPF6:            return 3'd6;
        default:              return 3'd1;
      endcase
    endfunction

    function logic [OW_CNT_W-1:0] offset_wiper_total(logic [KIND_W-1:0] kind);
      case (kind)
        KIND_HPF1, KIND_HPF5, KIND_BPF2: return 2'd1;
        KIND_BPF6:                       return 2'd3;
        default:                         return 2'd0;
      endcase
    endfunction

    function void note_request(filter_req_t req);
      int base, slot, pick;
      filter_pick_t exp;
      if (!kind_valid(req.kind)) return;
      base = int'(req.kind) * TABLE_DEPTH;
      if (req.cmd == CMD_LOAD) begin
        slot = base + int'(req.entry);
        freq_tbl[slot]   = req.freq;
        cutoff_tbl[slot] = req.cutoff_wiper;
        offset_tbl[slot] = req.offset_wiper;
        loaded[slot]     = 1'b1;
        return;
      end
      pick = nearest_entry(req.kind, int'(req.cutoff));
      exp.match_index        = ENTRY_W'(pick);
      exp.cutoff_wiper_value = cutoff_tbl[base + pick];
      exp.offset_wiper_value = offset_tbl[base + pick];
      exp.cutoff_wiper_count = cutoff_wiper_total(req.kind);
      exp.offset_wiper_count = offset_wiper_total(req.kind);
      expected_picks.push_back(exp);
    endfunction

    function void check_field(string name, int want, int got);
      if (want != got) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_pick(filter_pick_t got);
      filter_pick_t exp;
      if (expected_picks.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual match_index %0d",
                   $time, got.match_index);
        return;
      end
      exp = expected_picks.pop_front();
      check_field("match_index", exp.match_index, got.match_index);
      check_field("cutoff_wiper_value", exp.cutoff_wiper_value, got.cutoff_wiper_value);
      check_field("offset_wiper_value", exp.offset_wiper_value, got.offset_wiper_value);
      check_field("cutoff_wiper_count", exp.cutoff_wiper_count, got.cutoff_wiper_count);
      check_field("offset_wiper_count", exp.offset_wiper_count, got.offset_wiper_count);
    endfunction

    function int pending();
      return expected_picks.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [CMD_W-1:0]     in_cmd;
  logic [KIND_W-1:0]    in_filter_kind;
  logic [ENTRY_W-1:0]   in_entry_index;
  logic [FREQ_W-1:0]    in_entry_freq;
  logic [WIPER_W-1:0]   in_entry_cutoff_wiper;
  logic [WIPER_W-1:0]   in_entry_offset_wiper;
  logic [FREQ_W-1:0]    in_cutoff_freq;
  logic                 out_valid;
  logic [ENTRY_W-1:0]   out_match_index;
  logic [WIPER_W-1:0]   out_cutoff_wiper_value;
  logic [WIPER_W-1:0]   out_offset_wiper_value;
  logic [CW_CNT_W-1:0]  out_cutoff_wiper_count;
  logic [OW_CNT_W-1:0]  out_offset_wiper_count;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CNT_W-1:0]     cfg_data;

  nearest_cutoff_table_search dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_cmd                 (in_cmd),
    .in_filter_kind         (in_filter_kind),
    .in_entry_index         (in_entry_index),
    .in_entry_freq          (in_entry_freq),
    .in_entry_cutoff_wiper  (in_entry_cutoff_wiper),
    .in_entry_offset_wiper  (in_entry_offset_wiper),
    .in_cutoff_freq         (in_cutoff_freq),
    .out_valid              (out_valid),
    .out_match_index        (out_match_index),
    .out_cutoff_wiper_value (out_cutoff_wiper_value),
    .out_offset_wiper_value (out_offset_wiper_value),
    .out_cutoff_wiper_count (out_cutoff_wiper_count),
    .out_offset_wiper_count (out_offset_wiper_count),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data)
  );

  cutoff_predictor pred = new();
  int stalled_cycles = 0;
  int items;
  bit steady;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      stalled_cycles <= 0;
    end else begin
      if (out_valid)
        pred.check_pick('{out_match_index, out_cutoff_wiper_value, out_offset_wiper_value,
                          out_cutoff_wiper_count, out_offset_wiper_count});
      if ((start && !busy) || (cfg_valid && cfg_ready) || out_valid)
        stalled_cycles <= 0;
      else
        stalled_cycles <= stalled_cycles + 1;
    end
  end

  initial begin
    do @(posedge clk); while (stalled_cycles < STALL_LIMIT);
    $display("testbench: FAIL");
    $finish;
  end

  // start stays high when the next transaction follows at once
  task automatic pace_sender();
    int r, gap;
    r = $urandom_range(0, 99);
    if (steady || r < 55) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 60);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_req(input filter_req_t req);
    in_cmd                <= req.cmd;
    in_filter_kind        <= req.kind;
    in_entry_index        <= req.entry;
    in_entry_freq         <= req.freq;
    in_entry_cutoff_wiper <= req.cutoff_wiper;
    in_entry_offset_wiper <= req.offset_wiper;
    in_cutoff_freq        <= req.cutoff;
    start                 <= 1'b1;
    do @(posedge clk); while (busy);
    pred.note_request(req);
    if (pred.kind_valid(req.kind)) items++;
    pace_sender();
  endtask

  task automatic load_entry(input logic [KIND_W-1:0] kind, input int idx, input int f,
                            input int cw, input int ow);
    filter_req_t req;
    req.cmd          = CMD_LOAD;
    req.kind         = kind;
    req.entry        = ENTRY_W'(idx);
    req.freq         = FREQ_W'(f);
    req.cutoff_wiper = WIPER_W'(cw);
    req.offset_wiper = WIPER_W'(ow);
    req.cutoff       = FREQ_W'($urandom);
    send_req(req);
  endtask

  task automatic query_cutoff(input logic [KIND_W-1:0] kind, input int f);
    filter_req_t req;
    req.cmd          = CMD_QUERY;
    req.kind         = kind;
    req.entry        = ENTRY_W'($urandom);
    req.freq         = FREQ_W'($urandom);
    req.cutoff_wiper = WIPER_W'($urandom);
    req.offset_wiper = WIPER_W'($urandom);
    req.cutoff       = FREQ_W'(f);
    send_req(req);
  endtask

  // ascending table of n entries, with occasional repeated frequencies
  task automatic load_ramp(input logic [KIND_W-1:0] kind, input int n);
    int f, room, i;
    f = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 4000));
    for (i = 0; i < n; i++) begin
      load_entry(kind, i, f, $urandom_range(0, 255), $urandom_range(0, 255));
      room = (65535 - f) / (n - i);
      if ($urandom_range(0, 5) != 0) f += int'($urandom_range(0, room));
    end
  endtask

  // aims at stored frequencies, midpoints (ties) and both ends of the table
  function automatic int pick_cutoff(input logic [KIND_W-1:0] kind);
    int n, base, j, a, b, v;
    n    = pred.scan_len(kind);
    base = int'(kind) * TABLE_DEPTH;
    j    = $urandom_range(0, n - 1);
    a    = pred.freq_tbl[base + j];
    b    = (j + 1 < n) ? int'(pred.freq_tbl[base + j + 1]) : a;
    case ($urandom_range(0, 9))
      0, 1:    v = a;
      2, 3, 4: v = (a + b) / 2;
      5:       v = (a + b) / 2 + 1;
      6:       v = int'(pred.freq_tbl[base]) - int'($urandom_range(1, 50));
      7:       v = int'(pred.freq_tbl[base + n - 1]) + int'($urandom_range(1, 50));
      8:       v = ($urandom_range(0, 1) == 0) ? 0 : 65535;
      default: v = $urandom_range(0, 65535);
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v;
  endfunction

  function automatic logic [CNT_W-1:0] random_count(input logic [KIND_W-1:0] kind);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return CNT_W'(1);
    if (r < 24 && pred.loaded_upto(kind, TABLE_DEPTH))
      return ($urandom_range(0, 1) == 0) ? CNT_W'(TABLE_DEPTH)
                                         : CNT_W'($urandom_range(TABLE_DEPTH + 1, 2**CNT_W - 1));
    if (r < 32) return CNT_W'($urandom_range(13, 40));
    return CNT_W'($urandom_range(2, 12));
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    pred.set_count(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    do @(posedge clk); while (pred.pending() != 0);
  endtask

  // loads leave no result behind, so give the block time to go idle
  task automatic settle();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int phase, actions, r, n, kk;
    logic [KIND_W-1:0] kind;
    logic [CNT_W-1:0] cnt;

    rst_n                 <= 1'b0;
    start                 <= 1'b0;
    in_cmd                <= '0;
    in_filter_kind        <= '0;
    in_entry_index        <= '0;
    in_entry_freq         <= '0;
    in_entry_cutoff_wiper <= '0;
    in_entry_offset_wiper <= '0;
    in_cutoff_freq        <= '0;
    cfg_valid             <= 1'b0;
    cfg_index             <= '0;
    cfg_data              <= '0;
    items  = 0;
    steady = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // hpf1 and hpf5 keep their reset counts into the first random phase
    write_reg(REG_LPF1, 9'd0);
    write_reg(REG_LPF5, 9'd1);
    write_reg(REG_BPF2, 9'd2);
    write_reg(REG_BPF6, 9'd4);
    write_reg(REG_SPARE6, 9'h1FF);
    write_reg(REG_SPARE7, 9'd0);

    load_entry(KIND_UNUSED6, 255, 65535, 255, 255);
    query_cutoff(KIND_UNUSED7, 65535);
    load_entry(KIND_LPF1, 0, 40000, 8'hA5, 8'h5A);
    query_cutoff(KIND_LPF1, 65535);   // zero count answers with entry 0
    query_cutoff(KIND_LPF1, 0);
    load_entry(KIND_LPF5, 0, 0, 255, 0);
    query_cutoff(KIND_LPF5, 0);
    query_cutoff(KIND_LPF5, 65535);
    load_entry(KIND_BPF2, 0, 1000, 11, 22);
    load_entry(KIND_BPF2, 1, 2000, 33, 44);
    query_cutoff(KIND_BPF2, 1500);    // equal distance, upper entry wins
    query_cutoff(KIND_BPF2, 1499);
    query_cutoff(KIND_BPF2, 999);
    query_cutoff(KIND_BPF2, 2001);
    query_cutoff(KIND_BPF2, 2000);
    // out of order table
    load_entry(KIND_BPF6, 0, 500, 1, 2);
    load_entry(KIND_BPF6, 1, 100, 3, 4);
    load_entry(KIND_BPF6, 2, 300, 5, 6);
    load_entry(KIND_BPF6, 3, 65535, 7, 8);
    query_cutoff(KIND_BPF6, 200);
    query_cutoff(KIND_BPF6, 600);
    query_cutoff(KIND_BPF6, 65535);
    load_entry(KIND_BPF6, 255, 65535, 255, 255);

    phase = 0;
    while (items < ITEM_TARGET) begin
      if (phase > 0) begin
        settle();
        for (kk = 0; kk < KINDS_DEFINED; kk++) begin
          cnt = random_count(KIND_W'(kk));
          if (kk == REG_LPF1 && phase == 1) cnt = CNT_W'(TABLE_DEPTH);
          if (kk == REG_LPF1 && phase == 2) cnt = '1;
          write_reg(CFG_IDX_W'(kk), cnt);
        end
        write_reg(REG_SPARE6, CNT_W'($urandom));
        write_reg(REG_SPARE7, CNT_W'($urandom));
      end
      steady = ($urandom_range(0, 3) == 0);
      if (phase == 1) load_ramp(KIND_LPF1, TABLE_DEPTH);
      actions = $urandom_range(30, 80);
      repeat (actions) begin
        r    = $urandom_range(0, 99);
        kind = KIND_W'($urandom_range(0, KIND_COUNT - 1));
        if (r < 10) begin
          load_entry(KIND_W'($urandom_range(0, 2**KIND_W - 1)), $urandom_range(0, 255),
                     $urandom_range(0, 65535), $urandom_range(0, 255), $urandom_range(0, 255));
        end else if (r < 14) begin
          query_cutoff(KIND_W'($urandom_range(KIND_COUNT, 2**KIND_W - 1)),
                       $urandom_range(0, 65535));
        end else if (r < 16) begin
          hold_until_drained();
        end else if (!pred.loaded_upto(kind, pred.scan_len(kind)) ||
                     (r < 24 && pred.used_entries(kind) <= 64)) begin
          n = pred.scan_len(kind) + int'($urandom_range(0, 3));
          if (n > TABLE_DEPTH) n = TABLE_DEPTH;
          load_ramp(kind, n);
        end else begin
          query_cutoff(kind, pick_cutoff(kind));
        end
      end
      phase++;
    end

    settle();
    if (pred.errors == 0 && pred.pending() == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
